// ===== sv/rsi_pkg.sv =====
package rsi_pkg;

  // field widths
  localparam int VALUE_BITS  = 31;
  localparam int RADIX_BITS  = 6;
  localparam int SYMBOL_BITS = 8;
  localparam int STATUS_BITS = 3;

  // width of one multiply-add result before the range check
  localparam int SUM_BITS = VALUE_BITS + RADIX_BITS + 1;

  // radix register
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0] RADIX_UNARY = RADIX_BITS'(1);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);

  // status codes, lower code wins when several errors meet
  localparam logic [STATUS_BITS-1:0] ST_OK           = STATUS_BITS'(0);
  localparam logic [STATUS_BITS-1:0] ST_BAD_RADIX    = STATUS_BITS'(1);
  localparam logic [STATUS_BITS-1:0] ST_LEADING_ZERO = STATUS_BITS'(2);
  localparam logic [STATUS_BITS-1:0] ST_BAD_DIGIT    = STATUS_BITS'(3);
  localparam logic [STATUS_BITS-1:0] ST_OVERFLOW     = STATUS_BITS'(4);

  // character codes
  localparam logic [SYMBOL_BITS-1:0] CHAR_ZERO     = SYMBOL_BITS'(48);
  localparam logic [SYMBOL_BITS-1:0] CHAR_ONE      = SYMBOL_BITS'(49);
  localparam logic [SYMBOL_BITS-1:0] CHAR_NINE     = SYMBOL_BITS'(57);
  localparam logic [SYMBOL_BITS-1:0] CHAR_UPPER_A  = SYMBOL_BITS'(65);
  localparam logic [SYMBOL_BITS-1:0] CHAR_UPPER_Z  = SYMBOL_BITS'(90);
  localparam logic [SYMBOL_BITS-1:0] LETTER_OFFSET = SYMBOL_BITS'(55);

  // one character request as held in the input register
  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   last;
  } item_t;

  // decoded digit
  typedef struct packed {
    logic                  ok;
    logic [RADIX_BITS-1:0] val;
  } digit_t;

  // map a character to its digit value, 0-9 then A-Z
  function automatic digit_t digit_of(input logic [SYMBOL_BITS-1:0] sym);
    digit_t                 d;
    logic [SYMBOL_BITS-1:0] t;
    d.ok  = 1'b0;
    d.val = '0;
    t     = '0;
    if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
      t     = sym - CHAR_ZERO;
      d.ok  = 1'b1;
      d.val = t[RADIX_BITS-1:0];
    end else if (sym >= CHAR_UPPER_A && sym <= CHAR_UPPER_Z) begin
      t     = sym - LETTER_OFFSET;
      d.ok  = 1'b1;
      d.val = t[RADIX_BITS-1:0];
    end
    return d;
  endfunction

  // keep the lowest nonzero error code
  function automatic logic [STATUS_BITS-1:0] note_error(
    input logic [STATUS_BITS-1:0] cur,
    input logic [STATUS_BITS-1:0] code
  );
    logic [STATUS_BITS-1:0] r;
    r = cur;
    if (cur == ST_OK || code < cur) begin
      r = code;
    end
    return r;
  endfunction

endpackage

// ===== sv/rsi_in_reg.sv =====
module rsi_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsi_pkg::item_t in_item,
  input  logic           s_take,
  output logic           s_valid,
  output rsi_pkg::item_t s_item
);

  logic           s_valid_r;
  logic           s_valid_nxt;
  rsi_pkg::item_t s_item_r;

  // room when empty or when the held request moves on this cycle
  assign in_ready = !s_valid_r || s_take;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_ready) begin
      s_valid_nxt = in_valid;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item_r <= in_item;
    end
  end

  assign s_valid = s_valid_r;
  assign s_item  = s_item_r;

endmodule

// ===== sv/rsi_core.sv =====
module rsi_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rsi_pkg::RADIX_BITS-1:0]      radix,
  input  logic                                s_valid,
  input  rsi_pkg::item_t                      s_item,
  output logic                                s_take,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rsi_pkg::VALUE_BITS-1:0]      out_value,
  output logic [rsi_pkg::STATUS_BITS-1:0]     out_status
);

  logic [rsi_pkg::VALUE_BITS-1:0]  acc_r;
  logic [rsi_pkg::VALUE_BITS-1:0]  acc_nxt;
  logic                            at_first_r;
  logic                            at_first_nxt;
  logic [rsi_pkg::STATUS_BITS-1:0] err_r;
  logic [rsi_pkg::STATUS_BITS-1:0] err_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [rsi_pkg::VALUE_BITS-1:0]  out_value_r;
  logic [rsi_pkg::VALUE_BITS-1:0]  out_value_nxt;
  logic [rsi_pkg::STATUS_BITS-1:0] out_status_r;
  logic [rsi_pkg::STATUS_BITS-1:0] out_status_nxt;

  rsi_pkg::digit_t                 dig;
  logic                            radix_ok;
  logic                            digit_ok;
  logic [rsi_pkg::STATUS_BITS-1:0] err_chk;
  logic [rsi_pkg::STATUS_BITS-1:0] err_new;
  logic [rsi_pkg::VALUE_BITS-1:0]  acc_new;
  logic [rsi_pkg::SUM_BITS-1:0]    acc_ext;
  logic [rsi_pkg::SUM_BITS-1:0]    radix_ext;
  logic [rsi_pkg::SUM_BITS-1:0]    dig_ext;
  logic [rsi_pkg::SUM_BITS-1:0]    sum;
  logic                            ovf;

  // a non-final character never waits; a final one needs the result slot
  assign s_take = s_valid && (!s_item.last || !out_valid_r || out_ready);

  // digit decode and checks
  always_comb begin
    dig      = rsi_pkg::digit_of(s_item.symbol);
    radix_ok = (radix >= rsi_pkg::RADIX_UNARY) && (radix <= rsi_pkg::RADIX_MAX);
    if (radix == rsi_pkg::RADIX_UNARY) begin
      digit_ok = (s_item.symbol == rsi_pkg::CHAR_ONE);
    end else begin
      digit_ok = dig.ok && (dig.val < radix);
    end
    err_chk = err_r;
    if (!radix_ok) begin
      err_chk = rsi_pkg::note_error(err_chk, rsi_pkg::ST_BAD_RADIX);
    end
    if (at_first_r && s_item.symbol == rsi_pkg::CHAR_ZERO) begin
      err_chk = rsi_pkg::note_error(err_chk, rsi_pkg::ST_LEADING_ZERO);
    end
    if (radix_ok && !digit_ok) begin
      err_chk = rsi_pkg::note_error(err_chk, rsi_pkg::ST_BAD_DIGIT);
    end
  end

  // horner step: acc * radix + digit, with range check
  always_comb begin
    acc_ext   = rsi_pkg::SUM_BITS'(acc_r);
    radix_ext = rsi_pkg::SUM_BITS'(radix);
    dig_ext   = rsi_pkg::SUM_BITS'(dig.val);
    sum       = acc_ext * radix_ext + dig_ext;
    ovf       = |sum[rsi_pkg::SUM_BITS-1:rsi_pkg::VALUE_BITS];
    err_new   = err_chk;
    acc_new   = acc_r;
    if (err_chk == rsi_pkg::ST_OK) begin
      if (ovf) begin
        err_new = rsi_pkg::note_error(err_chk, rsi_pkg::ST_OVERFLOW);
      end else begin
        acc_new = sum[rsi_pkg::VALUE_BITS-1:0];
      end
    end
  end

  // string state and result register
  always_comb begin
    acc_nxt        = acc_r;
    at_first_nxt   = at_first_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (s_take) begin
      if (s_item.last) begin
        acc_nxt        = '0;
        at_first_nxt   = 1'b1;
        err_nxt        = rsi_pkg::ST_OK;
        out_valid_nxt  = 1'b1;
        out_status_nxt = err_new;
        out_value_nxt  = (err_new == rsi_pkg::ST_OK) ? acc_new : '0;
      end else begin
        acc_nxt      = acc_new;
        at_first_nxt = 1'b0;
        err_nxt      = err_new;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      at_first_r  <= 1'b1;
      err_r       <= rsi_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      at_first_r  <= at_first_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  // an error result never carries a value
  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != rsi_pkg::ST_OK |-> out_value_r == '0)
    else $error("error result with nonzero value");

  // a final character leaves the string state cleared
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s_take && s_item.last |=> at_first_r && acc_r == '0 && err_r == rsi_pkg::ST_OK)
    else $error("string state not cleared after final character");

  // at the start of a string nothing is accumulated yet
  a_first_empty: assert property (@(posedge clk) disable iff (!rst_n)
    at_first_r |-> acc_r == '0 && err_r == rsi_pkg::ST_OK)
    else $error("string start with stale state");

  // a final character is never taken over an unread result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s_take && s_item.last && out_valid_r |-> out_ready)
    else $error("result overwritten");
`endif

endmodule

// ===== sv/radix_string_to_integer.sv =====
// path: a character request is held in the input register; a final character is taken,
//   and its result loaded into the result register, only once no unread result is held
// throughput: one character per cycle, set by the 31 x 6 bit multiply-add and range check
//   between the input register and the string state, unless a final character waits
// reset: synchronous, active low; radix returns to 10, partial value and error cleared,
//   both pipeline registers emptied
module radix_string_to_integer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rsi_pkg::SYMBOL_BITS-1:0]     in_symbol,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rsi_pkg::VALUE_BITS-1:0]      out_value,
  output logic [rsi_pkg::STATUS_BITS-1:0]     out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rsi_pkg::RADIX_BITS-1:0]      cfg_radix
);

  logic [rsi_pkg::RADIX_BITS-1:0] radix_r;
  logic [rsi_pkg::RADIX_BITS-1:0] radix_nxt;
  rsi_pkg::item_t                 in_item;
  rsi_pkg::item_t                 s_item;
  logic                           s_valid;
  logic                           s_take;

  // radix register, always writable
  assign cfg_ready = 1'b1;

  always_comb begin
    radix_nxt = radix_r;
    if (cfg_valid && cfg_ready) begin
      radix_nxt = cfg_radix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rsi_pkg::RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // pack the input request
  always_comb begin
    in_item.symbol = in_symbol;
    in_item.last   = in_last;
  end

  rsi_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_take   (s_take),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  rsi_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix      (radix_r),
    .s_valid    (s_valid),
    .s_item     (s_item),
    .s_take     (s_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

// ===== verif/rsi_checker.sv =====
`timescale 1ns / 1ps
module rsi_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [rsi_pkg::SYMBOL_BITS-1:0] in_symbol,
  input  logic                            in_last,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [rsi_pkg::VALUE_BITS-1:0]  out_value,
  input  logic [rsi_pkg::STATUS_BITS-1:0] out_status,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rsi_pkg::RADIX_BITS-1:0]  cfg_radix,
  output int                              mismatches,
  output int                              outstanding,
  output int                              results_checked
);

  localparam longint unsigned VALUE_LIMIT = (64'd1 << rsi_pkg::VALUE_BITS) - 64'd1;

  typedef struct packed {
    logic [rsi_pkg::VALUE_BITS-1:0]  value;
    logic [rsi_pkg::STATUS_BITS-1:0] status;
  } parse_result_t;

  // predicted results, oldest first
  parse_result_t parsed_q[$];

  // shadow of the radix register and the string being parsed
  logic [rsi_pkg::RADIX_BITS-1:0]  radix_shadow  = rsi_pkg::RADIX_RESET;
  logic [rsi_pkg::VALUE_BITS-1:0]  partial_value = '0;
  logic                            string_start  = 1'b1;
  logic [rsi_pkg::STATUS_BITS-1:0] string_status = rsi_pkg::ST_OK;

  // character to digit value, -1 when it is no digit at all
  function automatic int digit_value(input logic [rsi_pkg::SYMBOL_BITS-1:0] sym);
    if (sym >= rsi_pkg::CHAR_ZERO && sym <= rsi_pkg::CHAR_NINE)
      return int'(sym - rsi_pkg::CHAR_ZERO);
    if (sym >= rsi_pkg::CHAR_UPPER_A && sym <= rsi_pkg::CHAR_UPPER_Z)
      return int'(sym - rsi_pkg::LETTER_OFFSET);
    return -1;
  endfunction

  // the lower nonzero code wins
  function automatic logic [rsi_pkg::STATUS_BITS-1:0] worse_of(
    input logic [rsi_pkg::STATUS_BITS-1:0] held,
    input logic [rsi_pkg::STATUS_BITS-1:0] code
  );
    return (held == rsi_pkg::ST_OK || code < held) ? code : held;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // one character through the horner step
  task automatic parse_symbol(input logic [rsi_pkg::SYMBOL_BITS-1:0] sym,
                              input logic final_char);
    int               digit;
    logic             radix_good;
    logic             digit_good;
    longint unsigned  grown;
    parse_result_t    res;
    digit      = digit_value(sym);
    radix_good = (radix_shadow >= rsi_pkg::RADIX_UNARY) &&
                 (radix_shadow <= rsi_pkg::RADIX_MAX);
    if (!radix_good) string_status = worse_of(string_status, rsi_pkg::ST_BAD_RADIX);
    if (string_start && sym == rsi_pkg::CHAR_ZERO)
      string_status = worse_of(string_status, rsi_pkg::ST_LEADING_ZERO);
    // unary takes only ones, any other base the digits below it
    if (radix_shadow == rsi_pkg::RADIX_UNARY) digit_good = (sym == rsi_pkg::CHAR_ONE);
    else digit_good = (digit >= 0) && (digit < int'(radix_shadow));
    if (radix_good && !digit_good)
      string_status = worse_of(string_status, rsi_pkg::ST_BAD_DIGIT);
    // value frozen once anything went wrong
    if (string_status == rsi_pkg::ST_OK) begin
      grown = 64'(partial_value) * 64'(radix_shadow) + 64'(digit);
      if (grown > VALUE_LIMIT) string_status = worse_of(string_status, rsi_pkg::ST_OVERFLOW);
      else partial_value = grown[rsi_pkg::VALUE_BITS-1:0];
    end
    string_start = 1'b0;
    if (final_char) begin
      res.value  = (string_status == rsi_pkg::ST_OK) ? partial_value : '0;
      res.status = string_status;
      parsed_q.push_back(res);
      partial_value = '0;
      string_start  = 1'b1;
      string_status = rsi_pkg::ST_OK;
    end
  endtask

  // compare one result with the oldest prediction
  task automatic check_result(
    input logic [rsi_pkg::VALUE_BITS-1:0]  value,
    input logic [rsi_pkg::STATUS_BITS-1:0] status
  );
    parse_result_t want;
    if (parsed_q.size() == 0) begin
      report_mismatch($sformatf("result value=%0d status=%0d with nothing expected",
                                value, status));
      return;
    end
    want = parsed_q.pop_front();
    results_checked++;
    if (value !== want.value)
      report_mismatch($sformatf("value %0d, expected %0d", value, want.value));
    if (status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
  endtask

  // watch all three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      parsed_q.delete();
      radix_shadow  = rsi_pkg::RADIX_RESET;
      partial_value = '0;
      string_start  = 1'b1;
      string_status = rsi_pkg::ST_OK;
    end else begin
      if (in_valid && in_ready) parse_symbol(in_symbol, in_last);
      if (cfg_valid && cfg_ready) radix_shadow = cfg_radix;
      if (out_valid && out_ready) check_result(out_value, out_status);
    end
    outstanding = parsed_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int RANDOM_ITEMS  = 1650;
  localparam int CALM_TAIL     = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_REQUESTS = 40;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 500000;

  typedef enum int {
    KIND_PLAIN,
    KIND_NEAR_LIMIT,
    KIND_LEADING_ZERO,
    KIND_NOISE
  } string_kind_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic [rsi_pkg::SYMBOL_BITS-1:0] in_symbol = '0;
  logic                            in_last   = 1'b0;
  logic                            out_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [rsi_pkg::RADIX_BITS-1:0]  cfg_radix = rsi_pkg::RADIX_RESET;
  logic                            in_ready;
  logic                            out_valid;
  logic [rsi_pkg::VALUE_BITS-1:0]  out_value;
  logic [rsi_pkg::STATUS_BITS-1:0] out_status;
  logic                            cfg_ready;

  int mismatches;
  int outstanding;
  int results_checked;

  // stimulus bookkeeping
  logic [rsi_pkg::RADIX_BITS-1:0] radix_now     = rsi_pkg::RADIX_RESET;
  int                             chars_sent    = 0;
  int                             strings_sent  = 0;
  int                             radix_writes  = 0;
  int                             gap_odds      = 4;
  int                             stall_odds    = 4;
  int                             hold_requests = 0;
  bit                             pressure_on   = 1'b0;
  bit                             calm_tail     = 1'b0;
  int                             odds_menu[3]  = '{0, 3, 8};

  // receiver state and run-limit counter, each private to its process
  int stall_left   = 0;
  int hold_left    = 0;
  int holds_served = 0;
  int cycle_count  = 0;

  radix_string_to_integer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_symbol  (in_symbol),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_radix  (cfg_radix)
  );

  rsi_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_symbol       (in_symbol),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_radix       (cfg_radix),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: long hold on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [rsi_pkg::SYMBOL_BITS-1:0] char_of(input int digit);
    return (digit < 10) ? rsi_pkg::CHAR_ZERO + rsi_pkg::SYMBOL_BITS'(digit)
                        : rsi_pkg::LETTER_OFFSET + rsi_pkg::SYMBOL_BITS'(digit);
  endfunction

  // a digit legal in the radix, or any digit when the radix itself is bad
  function automatic logic [rsi_pkg::SYMBOL_BITS-1:0] any_digit(
    input logic [rsi_pkg::RADIX_BITS-1:0] r
  );
    if (r == rsi_pkg::RADIX_UNARY) return rsi_pkg::CHAR_ONE;
    if (r > rsi_pkg::RADIX_UNARY && r <= rsi_pkg::RADIX_MAX)
      return char_of($urandom_range(0, r - 1));
    return char_of($urandom_range(0, int'(rsi_pkg::RADIX_MAX) - 1));
  endfunction

  function automatic logic [rsi_pkg::SYMBOL_BITS-1:0] lead_digit(
    input logic [rsi_pkg::RADIX_BITS-1:0] r
  );
    if (r == rsi_pkg::RADIX_UNARY) return rsi_pkg::CHAR_ONE;
    if (r > rsi_pkg::RADIX_UNARY && r <= rsi_pkg::RADIX_MAX)
      return char_of($urandom_range(1, r - 1));
    return char_of($urandom_range(1, int'(rsi_pkg::RADIX_MAX) - 1));
  endfunction

  // digits after which the value may pass the top of the range
  function automatic int fit_length(input logic [rsi_pkg::RADIX_BITS-1:0] r);
    longint unsigned span;
    int              n;
    span = 1;
    n    = 0;
    while (span < (64'd1 << rsi_pkg::VALUE_BITS)) begin
      span = span * r;
      n++;
    end
    return n;
  endfunction

  // mostly legal bases, with the extremes and the bad ones now and then
  function automatic logic [rsi_pkg::RADIX_BITS-1:0] pick_radix();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return rsi_pkg::RADIX_BITS'($urandom_range(2, int'(rsi_pkg::RADIX_MAX)));
    if (roll < 75) return rsi_pkg::RADIX_UNARY;
    if (roll < 88) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return rsi_pkg::RADIX_MAX;
        default: return rsi_pkg::RADIX_MAX + rsi_pkg::RADIX_UNARY;
      endcase
    end
    return rsi_pkg::RADIX_BITS'($urandom_range(0, (1 << rsi_pkg::RADIX_BITS) - 1));
  endfunction

  // one character request, with an optional gap before it
  task automatic push_char(input logic [rsi_pkg::SYMBOL_BITS-1:0] sym,
                           input logic final_char);
    if (!pressure_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= final_char;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    if (final_char) strings_sent++;
  endtask

  // radix write once the block has drained
  task automatic write_radix(input logic [rsi_pkg::RADIX_BITS-1:0] r);
    in_valid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_radix <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_now = r;
    radix_writes++;
  endtask

  task automatic send_string(input string text);
    for (int i = 0; i < text.len(); i++) push_char(text[i], i == text.len() - 1);
  endtask

  task automatic random_string();
    string_kind_t                    kind;
    int                              roll;
    int                              len;
    int                              n;
    logic [rsi_pkg::SYMBOL_BITS-1:0] sym;
    roll = $urandom_range(0, 99);
    if (roll < 65) kind = KIND_PLAIN;
    else if (roll < 80) kind = KIND_NEAR_LIMIT;
    else if (roll < 90) kind = KIND_LEADING_ZERO;
    else kind = KIND_NOISE;
    len = $urandom_range(1, 8);
    if (kind == KIND_NEAR_LIMIT && radix_now > rsi_pkg::RADIX_UNARY &&
        radix_now <= rsi_pkg::RADIX_MAX) begin
      n   = fit_length(radix_now);
      len = $urandom_range(n - 1, n + 1);
    end
    for (int pos = 0; pos < len; pos++) begin
      // now and then the base changes part way through a string
      if (!calm_tail && pos > 0 && $urandom_range(0, 59) == 0) write_radix(pick_radix());
      if (kind == KIND_NOISE && $urandom_range(0, 1) == 0)
        sym = rsi_pkg::SYMBOL_BITS'($urandom_range(0, 255));
      else if (pos == 0 && kind == KIND_LEADING_ZERO) sym = rsi_pkg::CHAR_ZERO;
      else if (pos == 0) sym = lead_digit(radix_now);
      else sym = any_digit(radix_now);
      push_char(sym, pos == len - 1);
    end
  endtask

  initial begin
    int directed_chars;
    int string_index;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset base of ten, single zero, lower case and a top-bit byte
    send_string("0");
    send_string("a");
    push_char("1", 1'b0);
    push_char(8'hFF, 1'b1);
    // base 36: largest value that fits, then one past it
    write_radix(rsi_pkg::RADIX_MAX);
    send_string("ZIK0ZJ");
    send_string("ZIK0ZK");
    // unary count and a leading zero in unary
    write_radix(rsi_pkg::RADIX_UNARY);
    send_string("111");
    send_string("0");
    // both ends of the register, bad radix beating leading zero
    write_radix('0);
    send_string("5");
    write_radix('1);
    send_string("0");
    // base changed between two characters of one string
    write_radix(6'd2);
    push_char("1", 1'b0);
    write_radix(6'd16);
    push_char("F", 1'b1);
    directed_chars = chars_sent;

    // random strings
    string_index = 0;
    while (chars_sent - directed_chars < RANDOM_ITEMS) begin
      if (chars_sent - directed_chars > RANDOM_ITEMS - CALM_TAIL) begin
        calm_tail  = 1'b1;
        gap_odds   = 0;
        stall_odds = 0;
      end else if (string_index % 40 == 0) begin
        gap_odds   = odds_menu[$urandom_range(0, 2)];
        stall_odds = odds_menu[$urandom_range(0, 2)];
      end
      // result side held off while single-character strings keep coming
      if (string_index == 60) begin
        pressure_on = 1'b1;
        hold_requests <= hold_requests + 1;
        repeat (HOLD_REQUESTS) push_char(lead_digit(radix_now), 1'b1);
        pressure_on = 1'b0;
      end
      if (!calm_tail && $urandom_range(0, 11) == 0) write_radix(pick_radix());
      random_string();
      string_index++;
    end

    // drain
    in_valid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d strings of %0d characters over %0d radix writes",
             strings_sent, chars_sent, radix_writes);
    $display("%0d parsed values and status codes compared", results_checked);
    if (mismatches == 0 && outstanding == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
